>>> rtl/core/tq_pkg.sv
`default_nettype none
package tq_pkg;

  localparam int CoordW   = 32;
  localparam int NumCoord = 12;
  localparam int NumDiff  = 18;
  localparam int DiffW    = 33;
  localparam int SqW      = 66;
  localparam int CrossW   = 68;
  localparam int CrossMW  = 67;
  localparam int EsumW    = 69;
  localparam int VprodW   = 100;
  localparam int SixvW    = 103;
  localparam int VmagW    = 102;
  localparam int Sq2W     = 138;
  localparam int CubeW    = 207;
  localparam int VsqW     = 204;
  localparam int RemW     = 273;
  localparam int QcW      = 239;
  localparam int QualW    = 32;
  localparam int StatW    = 2;
  localparam int FloorW   = 63;
  localparam int CfgIdxW  = 2;
  localparam int InDataW  = NumCoord * CoordW;
  localparam int OutDataW = 40;

  typedef logic [StatW-1:0] stat_t;
  localparam stat_t StatOk       = 2'd0;
  localparam stat_t StatInverted = 2'd1;
  localparam stat_t StatDegen    = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgVolFloor = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLenFloor = 2'd1;

endpackage
`default_nettype wire

>>> rtl/core/tq_mul.sv
`default_nettype none
// Two-stage unsigned multiplier: 32x32 limb products, then shifted sum.
module tq_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int LW  = 32;
  localparam int NA  = (AW + LW - 1) / LW;
  localparam int NB  = (BW + LW - 1) / LW;
  localparam int PW  = AW + BW;
  localparam int SW  = (NA + NB) * LW;

  logic [NA*LW-1:0] a_pad;
  logic [NB*LW-1:0] b_pad;
  logic [2*LW-1:0]  pp_q [NA*NB];
  logic [SW-1:0]    sum_w;
  logic [PW-1:0]    p_q;

  assign a_pad = (NA*LW)'(a_i);
  assign b_pad = (NB*LW)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i*NB+j] <= a_pad[i*LW +: LW] * b_pad[j*LW +: LW];
        end
      end
    end
  end

  always_comb begin
    sum_w = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_w = sum_w + (SW'(pp_q[i*NB+j]) << (LW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_w[PW-1:0];
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> rtl/core/tetra_quality.sv
`default_nettype none
// Throughput: one tetrahedron per cycle; the pipeline stalls as a whole when
// the result is not taken. Depth is set by three pipelined multiplier levels
// and the 32 stages of the bitwise quotient/root search.
// Reset: asynchronous, active low; clears valid bits, floors return to 1.
module tetra_quality (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tq_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tq_pkg::FloorW-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz (32 bits each)
  input  logic [tq_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // quality [31:0], status [33:32], zero fill
  output logic [tq_pkg::OutDataW-1:0]    m_axis_tdata
);

  localparam int NSTG = 44;
  localparam int NBIT = tq_pkg::QualW;
  localparam int CA [6] = '{1, 2, 2, 0, 0, 1};
  localparam int CB [6] = '{2, 1, 0, 2, 1, 0};
  localparam int EP [6] = '{0, 0, 0, 1, 1, 2};
  localparam int EQ [6] = '{1, 2, 3, 2, 3, 3};

  logic [tq_pkg::FloorW-1:0] vfloor_q, lfloor_q;
  logic [NSTG-1:0]           vld_q;
  logic                      en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vfloor_q <= tq_pkg::FloorW'(1);
      lfloor_q <= tq_pkg::FloorW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tq_pkg::CfgVolFloor: vfloor_q <= cfg_data_i;
        tq_pkg::CfgLenFloor: lfloor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // stage 1: edge vectors
  logic signed [tq_pkg::DiffW-1:0] dif_d [tq_pkg::NumDiff];
  logic signed [tq_pkg::DiffW-1:0] dif_q [tq_pkg::NumDiff];

  always_comb begin
    logic [tq_pkg::CoordW-1:0] pa, pb;
    for (int e = 0; e < 6; e++) begin
      for (int c = 0; c < 3; c++) begin
        pa = s_axis_tdata[(EP[e]*3+c)*tq_pkg::CoordW +: tq_pkg::CoordW];
        pb = s_axis_tdata[(EQ[e]*3+c)*tq_pkg::CoordW +: tq_pkg::CoordW];
        dif_d[e*3+c] = $signed({pb[tq_pkg::CoordW-1], pb}) - $signed({pa[tq_pkg::CoordW-1], pa});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) dif_q <= dif_d;
  end

  // stage 2: magnitudes and signs
  logic [tq_pkg::DiffW-1:0] mag_q [tq_pkg::NumDiff];
  logic [tq_pkg::NumDiff-1:0] sgn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < tq_pkg::NumDiff; i++) begin
        mag_q[i] <= dif_q[i][tq_pkg::DiffW-1] ? tq_pkg::DiffW'(-dif_q[i])
                                               : tq_pkg::DiffW'(dif_q[i]);
        sgn_q[i] <= dif_q[i][tq_pkg::DiffW-1];
      end
    end
  end

  // stages 3-4: squares and cross-product terms
  logic [tq_pkg::SqW-1:0] sq_w [tq_pkg::NumDiff];
  logic [tq_pkg::SqW-1:0] cp_w [6];
  logic [5:0] cps_d, cps3_q, cps4_q;
  logic [tq_pkg::DiffW-1:0] abm_q [3][3];
  logic [2:0] abs_q [3];

  for (genvar g = 0; g < tq_pkg::NumDiff; g++) begin : g_sq
    tq_mul #(.AW(tq_pkg::DiffW), .BW(tq_pkg::DiffW)) u_sq (
      .clk_i (clk_i), .en_i (en), .a_i (mag_q[g]), .b_i (mag_q[g]), .p_o (sq_w[g])
    );
  end

  for (genvar g = 0; g < 6; g++) begin : g_cp
    tq_mul #(.AW(tq_pkg::DiffW), .BW(tq_pkg::DiffW)) u_cp (
      .clk_i (clk_i), .en_i (en), .a_i (mag_q[3+CA[g]]), .b_i (mag_q[6+CB[g]]),
      .p_o (cp_w[g])
    );
    assign cps_d[g] = sgn_q[3+CA[g]] ^ sgn_q[6+CB[g]];
  end

  // AB edge carried alongside; abm_q[0] is stage 3
  always_ff @(posedge clk_i) begin
    if (en) begin
      cps3_q <= cps_d;
      cps4_q <= cps3_q;
      for (int c = 0; c < 3; c++) abm_q[0][c] <= mag_q[c];
      abs_q[0] <= sgn_q[2:0];
      for (int s = 1; s < 3; s++) begin
        abm_q[s] <= abm_q[s-1];
        abs_q[s] <= abs_q[s-1];
      end
    end
  end

  // stage 5: cross product and edge sum
  function automatic logic signed [tq_pkg::CrossW-1:0] sgnv(
    input logic [tq_pkg::SqW-1:0] m, input logic s);
    logic signed [tq_pkg::CrossW-1:0] x;
    x = $signed(tq_pkg::CrossW'(m));
    return s ? -x : x;
  endfunction

  logic signed [tq_pkg::CrossW-1:0] cr_q [3];
  logic [tq_pkg::EsumW-1:0]         es_d, es5_q;

  always_comb begin
    es_d = '0;
    for (int i = 0; i < tq_pkg::NumDiff; i++) es_d = es_d + tq_pkg::EsumW'(sq_w[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cr_q[k] <= sgnv(cp_w[2*k], cps4_q[2*k]) - sgnv(cp_w[2*k+1], cps4_q[2*k+1]);
      end
      es5_q <= es_d;
    end
  end

  // stage 6: cross magnitudes, term signs
  logic [tq_pkg::CrossMW-1:0] crm_q [3];
  logic [2:0]                 vs6_q, vs7_q, vs8_q;
  logic [tq_pkg::EsumW-1:0]   es6_q, es7_q, es8_q, es9_q, es10_q;
  logic [tq_pkg::DiffW-1:0]   abm6_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        crm_q[k]  <= cr_q[k][tq_pkg::CrossW-1] ? tq_pkg::CrossMW'(-cr_q[k])
                                                : tq_pkg::CrossMW'(cr_q[k]);
        vs6_q[k]  <= cr_q[k][tq_pkg::CrossW-1] ^ abs_q[2][k];
        abm6_q[k] <= abm_q[2][k];
      end
      es6_q <= es5_q;
    end
  end

  // stages 7-8: triple product terms, edge sum squared
  logic [tq_pkg::VprodW-1:0] vp_w [3];
  logic [tq_pkg::Sq2W-1:0]   sq2_w;

  for (genvar g = 0; g < 3; g++) begin : g_vp
    tq_mul #(.AW(tq_pkg::DiffW), .BW(tq_pkg::CrossMW)) u_vp (
      .clk_i (clk_i), .en_i (en), .a_i (abm6_q[g]), .b_i (crm_q[g]), .p_o (vp_w[g])
    );
  end

  tq_mul #(.AW(tq_pkg::EsumW), .BW(tq_pkg::EsumW)) u_es2 (
    .clk_i (clk_i), .en_i (en), .a_i (es6_q), .b_i (es6_q), .p_o (sq2_w)
  );

  // stage 9: six-volume
  logic signed [tq_pkg::SixvW-1:0] sixv_d, sixv_q;
  logic [tq_pkg::Sq2W-1:0]         sq9_q, sq10_q;

  always_comb begin
    logic signed [tq_pkg::SixvW-1:0] x;
    sixv_d = '0;
    for (int k = 0; k < 3; k++) begin
      x      = $signed(tq_pkg::SixvW'(vp_w[k]));
      sixv_d = sixv_d + (vs8_q[k] ? -x : x);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vs7_q  <= vs6_q;
      vs8_q  <= vs7_q;
      es7_q  <= es6_q;
      es8_q  <= es7_q;
      es9_q  <= es8_q;
      sixv_q <= sixv_d;
      sq9_q  <= sq2_w;
    end
  end

  // stage 10: floor checks
  tq_pkg::stat_t            st_d, st10_q, st11_q, st12_q;
  logic [tq_pkg::VmagW-1:0] vm10_q;

  always_comb begin
    if (sixv_q[tq_pkg::SixvW-1] ||
        (tq_pkg::SixvW'(vfloor_q) > sixv_q[tq_pkg::SixvW-1:0])) begin
      st_d = tq_pkg::StatInverted;
    end else if ((es9_q == '0) || (tq_pkg::EsumW'(lfloor_q) > es9_q)) begin
      st_d = tq_pkg::StatDegen;
    end else begin
      st_d = tq_pkg::StatOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st10_q <= st_d;
      vm10_q <= sixv_q[tq_pkg::VmagW-1:0];
      es10_q <= es9_q;
      sq10_q <= sq9_q;
      st11_q <= st10_q;
      st12_q <= st11_q;
    end
  end

  // stages 11-12: V^2 and R^3
  logic [tq_pkg::VsqW-1:0]  vv_w;
  logic [tq_pkg::CubeW-1:0] cube_w;

  tq_mul #(.AW(tq_pkg::VmagW), .BW(tq_pkg::VmagW)) u_vv (
    .clk_i (clk_i), .en_i (en), .a_i (vm10_q), .b_i (vm10_q), .p_o (vv_w)
  );

  tq_mul #(.AW(tq_pkg::Sq2W), .BW(tq_pkg::EsumW)) u_cube (
    .clk_i (clk_i), .en_i (en), .a_i (sq10_q), .b_i (es10_q), .p_o (cube_w)
  );

  // stages 13-44: one quality bit per stage, MSB first.
  // rem = (V*2^32)^2 - q^2*R^3, qc = q*R^3; bit p taken if
  // 2^(p+1)*qc + 2^(2p)*R^3 <= rem
  logic [tq_pkg::RemW-1:0]  rem_q [NBIT-1];
  logic [tq_pkg::QcW-1:0]   qc_q  [NBIT-1];
  logic [tq_pkg::CubeW-1:0] c_q   [NBIT-1];
  logic [tq_pkg::QualW-1:0] q_q   [NBIT-1];
  tq_pkg::stat_t            st_q  [NBIT-1];

  logic [tq_pkg::RemW-1:0]  rin_w [NBIT];
  logic [tq_pkg::QcW-1:0]   qcin_w [NBIT];
  logic [tq_pkg::CubeW-1:0] cin_w [NBIT];
  logic [tq_pkg::QualW-1:0] qin_w [NBIT];
  tq_pkg::stat_t            stin_w [NBIT];
  logic [tq_pkg::RemW-1:0]  t_w [NBIT];
  logic [NBIT-1:0]          take_w;

  logic [tq_pkg::QualW-1:0] qout_q;
  tq_pkg::stat_t            stout_q;

  always_comb begin
    rin_w[0]  = tq_pkg::RemW'({vv_w, 64'b0});
    qcin_w[0] = '0;
    cin_w[0]  = cube_w;
    qin_w[0]  = '0;
    stin_w[0] = st12_q;
    for (int k = 1; k < NBIT; k++) begin
      rin_w[k]  = rem_q[k-1];
      qcin_w[k] = qc_q[k-1];
      cin_w[k]  = c_q[k-1];
      qin_w[k]  = q_q[k-1];
      stin_w[k] = st_q[k-1];
    end
    for (int k = 0; k < NBIT; k++) begin
      t_w[k] = (tq_pkg::RemW'(qcin_w[k]) << (NBIT - k)) +
               (tq_pkg::RemW'(cin_w[k]) << (2 * (NBIT - 1 - k)));
      take_w[k] = (t_w[k] <= rin_w[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NBIT - 1; k++) begin
        rem_q[k] <= take_w[k] ? rin_w[k] - t_w[k] : rin_w[k];
        qc_q[k]  <= take_w[k] ? qcin_w[k] + (tq_pkg::QcW'(cin_w[k]) << (NBIT - 1 - k))
                              : qcin_w[k];
        c_q[k]   <= cin_w[k];
        q_q[k]   <= qin_w[k] | (take_w[k] ? (tq_pkg::QualW'(1) << (NBIT - 1 - k)) : '0);
        st_q[k]  <= stin_w[k];
      end
      qout_q  <= (stin_w[NBIT-1] == tq_pkg::StatOk) ?
                 (qin_w[NBIT-1] | tq_pkg::QualW'(take_w[NBIT-1])) : '0;
      stout_q <= stin_w[NBIT-1];
    end
  end

  assign m_axis_tdata = tq_pkg::OutDataW'({stout_q, qout_q});

endmodule
`default_nettype wire

>>> rtl/core/tq_check.sv
`default_nettype none
module tq_check (
  input logic clk_i,
  input logic rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tq_pkg::OutDataW-1:0]    m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[33:32] == tq_pkg::StatOk ||
                       m_axis_tdata[33:32] == tq_pkg::StatInverted ||
                       m_axis_tdata[33:32] == tq_pkg::StatDegen))
    else $error("bad status code");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] != tq_pkg::StatOk)
      |-> (m_axis_tdata[31:0] == '0))
    else $error("rejected tetrahedron with non-zero quality");

endmodule

bind tetra_quality tq_check u_tq_check (.*);
`default_nettype wire
